// ===== design/qrs_pkg.sv =====
// Shared types and constants for the quadratic root solver.
// No dependencies; imported by every module in this folder.
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

    localparam int SQ_STEPS  = 32;  // one result bit per square root cell
    localparam int DIV_STEPS = 33;  // one quotient bit per divider cell

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_ONE  = 2'd1,
        CLS_TWO  = 2'd2,
        CLS_ALL  = 2'd3
    } root_class_t;

    // Coefficients and class riding along the square root row
    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        root_class_t        cls;
        logic               lin;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [63:0] rad;   // radicand, consumed two bits per cell from the top
        logic [33:0] rem;
        logic [31:0] root;
    } sq_t;

    // Two division lanes sharing one divisor
    typedef struct packed {
        root_class_t cls;
        logic [15:0] dv;
        logic [32:0] nq1;   // numerator bits shift out, quotient bits shift in
        logic [32:0] nq2;
        logic [15:0] r1;
        logic [15:0] r2;
        logic        neg1;
        logic        neg2;
    } dv_t;

    typedef struct packed {
        root_class_t cls;
        logic [31:0] root1;
        logic [31:0] root2;
        logic        ovf;
    } res_t;

endpackage

`default_nettype wire

// ===== design/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: product stages, square root row,
// divider row, saturation and output skid. Depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell.
//
//   channel   dir   handshake           payload
//   s_        in    s_valid / s_ready   s_coef_a, s_coef_b, s_coef_c (Q8.8)
//   m_        out   m_valid / m_ready   m_root_class, m_root_first, m_root_second, m_overflow
//
// One request per cycle while s_ready is high; the path runs through 3 front stages,
// 32 square root cells, 1 numerator stage, 33 divider cells and the output register.
// Reset clears the valid bits only. A stalled result moves into the skid
// register; s_ready drops only once the skid register is occupied.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_root_solver
    import qrs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_coef_a,
    input  wire logic signed [15:0] s_coef_b,
    input  wire logic signed [15:0] s_coef_c,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_root_class,
    output logic signed [31:0]      m_root_first,
    output logic signed [31:0]      m_root_second,
    output logic                    m_overflow
);

    logic en;
    logic skid_full_reg;
    logic out_vld_reg;
    res_t out_reg;
    res_t skid_reg;

    assign en      = !skid_full_reg;
    assign s_ready = en;

    // Stage 0: input register
    logic               v0_reg;
    logic signed [15:0] a0_reg, b0_reg, c0_reg;

    // Stage 1: products
    logic               v1_reg;
    logic signed [15:0] a1_reg, b1_reg, c1_reg;
    logic signed [31:0] bb_reg, ac_reg;

    // Stage 2: discriminant, class, radicand
    logic               v2_reg;
    sq_t                sq2_reg;
    logic signed [33:0] disc;
    sq_t                sq2_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_comb begin
        disc = 34'(bb_reg) - (34'(ac_reg) <<< 2);
        sq2_next.side.a   = a1_reg;
        sq2_next.side.b   = b1_reg;
        sq2_next.side.c   = c1_reg;
        sq2_next.side.lin = (a1_reg == 16'sd0);
        sq2_next.rem      = '0;
        sq2_next.root     = '0;
        sq2_next.rad      = '0;
        if (a1_reg != 16'sd0) begin
            if (disc == 34'sd0) begin
                sq2_next.side.cls = CLS_ONE;
            end else if (!disc[33]) begin
                sq2_next.side.cls = CLS_TWO;
                sq2_next.rad      = {1'b0, disc[32:0], 30'b0};
            end else begin
                sq2_next.side.cls = CLS_NONE;
            end
        end else if (b1_reg != 16'sd0) begin
            sq2_next.side.cls = CLS_ONE;
        end else begin
            sq2_next.side.cls = (c1_reg == 16'sd0) ? CLS_ALL : CLS_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a0_reg  <= s_coef_a;
            b0_reg  <= s_coef_b;
            c0_reg  <= s_coef_c;
            a1_reg  <= a0_reg;
            b1_reg  <= b0_reg;
            c1_reg  <= c0_reg;
            bb_reg  <= b0_reg * b0_reg;
            ac_reg  <= a0_reg * c0_reg;
            sq2_reg <= sq2_next;
        end
    end

    // Square root row
    logic sq_v [0:SQ_STEPS];
    sq_t  sq_d [0:SQ_STEPS];

    assign sq_v[0] = v2_reg;
    assign sq_d[0] = sq2_reg;

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_vld   (sq_v[i]),
            .in_data  (sq_d[i]),
            .out_vld  (sq_v[i+1]),
            .out_data (sq_d[i+1])
        );
    end

    // Numerator stage: signed numerators and divisor reduced to magnitudes
    logic               vn_reg;
    dv_t                dn_reg;
    dv_t                dn_next;
    side_t              sd;
    logic signed [33:0] nb, nl, sroot, n1, n2;
    logic signed [15:0] dsr;

    always_comb begin
        sd    = sq_d[SQ_STEPS].side;
        sroot = $signed({2'b00, sq_d[SQ_STEPS].root});
        nb    = -(34'(sd.b) <<< 15);
        nl    = -(34'(sd.c) <<< 16);
        n1    = sd.lin ? nl : (nb + sroot);
        n2    = sd.lin ? nl : (nb - sroot);
        dsr   = sd.lin ? sd.b : sd.a;
        dn_next.cls  = sd.cls;
        dn_next.dv   = dsr[15] ? 16'(-dsr) : dsr;
        dn_next.nq1  = n1[33] ? 33'(-n1) : n1[32:0];
        dn_next.nq2  = n2[33] ? 33'(-n2) : n2[32:0];
        dn_next.r1   = '0;
        dn_next.r2   = '0;
        dn_next.neg1 = n1[33] ^ dsr[15];
        dn_next.neg2 = n2[33] ^ dsr[15];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vn_reg <= 1'b0;
        end else if (en) begin
            vn_reg <= sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dn_reg <= dn_next;
        end
    end

    // Divider row
    logic dv_v [0:DIV_STEPS];
    dv_t  dv_d [0:DIV_STEPS];

    assign dv_v[0] = vn_reg;
    assign dv_d[0] = dn_reg;

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        qrs_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_vld   (dv_v[j]),
            .in_data  (dv_d[j]),
            .out_vld  (dv_v[j+1]),
            .out_data (dv_d[j+1])
        );
    end

    // Sign, saturate, mask absent roots
    dv_t                df;
    logic signed [33:0] q1, q2;
    logic               hi1, lo1, hi2, lo2, has_root;
    res_t               pres;
    logic               arrive;

    always_comb begin
        df  = dv_d[DIV_STEPS];
        q1  = df.neg1 ? -$signed({1'b0, df.nq1}) : $signed({1'b0, df.nq1});
        q2  = df.neg2 ? -$signed({1'b0, df.nq2}) : $signed({1'b0, df.nq2});
        hi1 = !q1[33] && (q1[32] || q1[31]);
        lo1 = q1[33] && !(q1[32] && q1[31]);
        hi2 = !q2[33] && (q2[32] || q2[31]);
        lo2 = q2[33] && !(q2[32] && q2[31]);
        has_root  = (df.cls == CLS_ONE) || (df.cls == CLS_TWO);
        pres.cls  = df.cls;
        pres.root1 = !has_root ? 32'h0 : hi1 ? 32'h7FFF_FFFF : lo1 ? 32'h8000_0000 : q1[31:0];
        pres.root2 = !has_root ? 32'h0 : hi2 ? 32'h7FFF_FFFF : lo2 ? 32'h8000_0000 : q2[31:0];
        pres.ovf   = has_root && (hi1 || lo1 || hi2 || lo2);
        arrive     = en && dv_v[DIV_STEPS];
    end

    // Output register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (!out_vld_reg || m_ready) begin
            out_vld_reg   <= skid_full_reg || arrive;
            skid_full_reg <= 1'b0;
        end else if (arrive) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_ready) begin
            out_reg <= skid_full_reg ? skid_reg : pres;
        end else if (arrive) begin
            skid_reg <= pres;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_root_class  = out_reg.cls;
    assign m_root_first  = out_reg.root1;
    assign m_root_second = out_reg.root2;
    assign m_overflow    = out_reg.ovf;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> out_vld_reg)
        else $error("skid register holds a request with no result in front");

    a_none_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_root_class == CLS_NONE || m_root_class == CLS_ALL)) |->
        (m_root_first == 32'sd0 && m_root_second == 32'sd0 && !m_overflow))
        else $error("absent roots carry a value or overflow");

    a_single_same: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_root_class == CLS_ONE) |-> (m_root_first == m_root_second))
        else $error("single root differs between fields");

endmodule

`default_nettype wire

// ===== design/qrs_sqrt_cell.sv =====
// One digit cell of the integer square root row.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qrs_sqrt_cell
    import qrs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire logic in_vld,
    input  wire sq_t  in_data,
    output logic      out_vld,
    output sq_t       out_data
);

    logic vld_reg;
    sq_t  data_reg;
    sq_t  data_next;
    logic [33:0] rem_sh;
    logic [33:0] trial;
    logic        ge;

    always_comb begin
        rem_sh = {in_data.rem[31:0], in_data.rad[63:62]};
        trial  = {in_data.root, 2'b01};
        ge     = (rem_sh >= trial);
        data_next      = in_data;
        data_next.rad  = {in_data.rad[61:0], 2'b00};
        data_next.rem  = ge ? (rem_sh - trial) : rem_sh;
        data_next.root = {in_data.root[30:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule

`default_nettype wire

// ===== design/qrs_div_cell.sv =====
// One restoring division cell, two lanes over a common divisor.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qrs_div_cell
    import qrs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire logic in_vld,
    input  wire dv_t  in_data,
    output logic      out_vld,
    output dv_t       out_data
);

    logic vld_reg;
    dv_t  data_reg;
    dv_t  data_next;
    logic [16:0] rsh1;
    logic [16:0] rsh2;
    logic [16:0] dv17;
    logic        ge1;
    logic        ge2;

    always_comb begin
        dv17 = {1'b0, in_data.dv};
        rsh1 = {in_data.r1, in_data.nq1[32]};
        rsh2 = {in_data.r2, in_data.nq2[32]};
        ge1  = (rsh1 >= dv17);
        ge2  = (rsh2 >= dv17);
        data_next     = in_data;
        data_next.r1  = 16'(ge1 ? (rsh1 - dv17) : rsh1);
        data_next.r2  = 16'(ge2 ? (rsh2 - dv17) : rsh2);
        data_next.nq1 = {in_data.nq1[31:0], ge1};
        data_next.nq2 = {in_data.nq2[31:0], ge2};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for quadratic_root_solver: directed table plus random coefficient
// sets, scored against typed rows or an in-bench root predictor. Depends on qrs_pkg.
`timescale 1ns / 1ps

module testbench;
    import qrs_pkg::*;

    localparam int LATENCY    = 70;
    localparam int N_RANDOM   = 730;
    localparam int WDOG_LIMIT = 20000;
    localparam int N_DIRECTED = 20;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_coef_a;
    logic signed [15:0] s_coef_b;
    logic signed [15:0] s_coef_c;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_root_class;
    logic signed [31:0] m_root_first;
    logic signed [31:0] m_root_second;
    logic               m_overflow;

    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        bit                 typed;  // expected result given in the row
        res_t               want;
    } coef_row_t;

    res_t      roots_pending[$];
    coef_row_t coef_table[N_DIRECTED];
    int        mismatches;
    int        n_checked;
    int        idle_cycles;
    bit        stim_done;
    bit        timed_out;
    int        hold_off;

    quadratic_root_solver dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_coef_a      (s_coef_a),
        .s_coef_b      (s_coef_b),
        .s_coef_c      (s_coef_c),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_root_class  (m_root_class),
        .m_root_first  (m_root_first),
        .m_root_second (m_root_second),
        .m_overflow    (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] saturate(longint x, inout logic ovf);
        if (x > 64'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (x < -64'sd2147483648) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return x[31:0];
    endfunction

    // SV division on longint truncates toward zero, as required
    function automatic res_t solve_roots(logic signed [15:0] ca, logic signed [15:0] cb,
                                         logic signed [15:0] cc);
        res_t   r;
        longint a, b, c, disc, s;
        a = ca; b = cb; c = cc;
        r = '{cls: CLS_NONE, root1: '0, root2: '0, ovf: 1'b0};
        if (a == 0) begin
            if (b == 0) begin
                r.cls = (c == 0) ? CLS_ALL : CLS_NONE;
            end else begin
                r.cls   = CLS_ONE;
                r.root1 = saturate((-c * 65536) / b, r.ovf);
                r.root2 = r.root1;
            end
        end else begin
            disc = b * b - 4 * a * c;
            if (disc == 0) begin
                r.cls   = CLS_ONE;
                r.root1 = saturate((-b * 32768) / a, r.ovf);
                r.root2 = r.root1;
            end else if (disc > 0) begin
                s = longint'(floor_sqrt(64'(disc) << 30));
                r.cls   = CLS_TWO;
                r.root1 = saturate((-b * 32768 + s) / a, r.ovf);
                r.root2 = saturate((-b * 32768 - s) / a, r.ovf);
            end
        end
        return r;
    endfunction

    function automatic coef_row_t row(int a, int b, int c);
        coef_row_t t;
        t.a = 16'(a); t.b = 16'(b); t.c = 16'(c);
        t.typed = 1'b0;
        t.want = '{cls: CLS_NONE, root1: '0, root2: '0, ovf: 1'b0};
        return t;
    endfunction

    function automatic coef_row_t row_exp(int a, int b, int c, root_class_t k,
                                          int r1, int r2, bit o);
        coef_row_t t;
        t = row(a, b, c);
        t.typed = 1'b1;
        t.want = '{cls: k, root1: r1, root2: r2, ovf: o};
        return t;
    endfunction

    initial begin
        coef_table[0]  = row_exp(0, 0, 0, CLS_ALL, 0, 0, 0);        // every number
        coef_table[1]  = row_exp(0, 0, 256, CLS_NONE, 0, 0, 0);     // no root at all
        coef_table[2]  = row_exp(0, 0, -32768, CLS_NONE, 0, 0, 0);
        coef_table[3]  = row_exp(0, 256, -512, CLS_ONE, 131072, 131072, 0); // x = 2
        coef_table[4]  = row_exp(0, 1, -32768, CLS_ONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
        coef_table[5]  = row_exp(0, 1, 32767, CLS_ONE, 32'h8001_0000, 32'h8001_0000, 0);
        coef_table[6]  = row_exp(256, 0, 256, CLS_NONE, 0, 0, 0);   // negative discriminant
        coef_table[7]  = row_exp(256, -512, 256, CLS_ONE, 65536, 65536, 0); // double root 1
        coef_table[8]  = row(256, 0, -1024);                         // +/-2
        coef_table[9]  = row(1, 32767, -32768);                      // roots 1 and -32768
        coef_table[10] = row(-32768, -32768, -32768);
        coef_table[11] = row(32767, 32767, 32767);
        coef_table[12] = row(-32768, 32767, 32767);
        coef_table[13] = row(32767, -32768, -32768);
        coef_table[14] = row(-1, -1, -1);
        coef_table[15] = row(1, 0, -32768);
        coef_table[16] = row(-32768, 0, 0);
        coef_table[17] = row(0, -32768, 32767);
        coef_table[18] = row(0, -1, 1);
        coef_table[19] = row(16'h5555, 16'hAAAA, 16'h5555);
    end

    // valid stays up across back-to-back requests; dropped only for a real gap
    task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                              logic signed [15:0] c);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_coef_a <= a;
        s_coef_b <= b;
        s_coef_c <= c;
        do @(posedge aclk); while (!s_ready);
        roots_pending.push_back(solve_roots(a, b, c));
    endtask

    // random coefficient with a bias toward zero, small magnitudes and extremes
    function automatic logic signed [15:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 16'sd0;
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2, 3: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
            default: return 16'($urandom);
        endcase
    endfunction

    // stimulus
    initial begin
        coef_row_t t;
        logic signed [15:0] ra, rb, rc;
        int k;
        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_coef_a <= '0;
        s_coef_b <= '0;
        s_coef_c <= '0;
        stim_done = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < N_DIRECTED; i++) begin
            t = coef_table[i];
            send_coefs(t.a, t.b, t.c);
            if (t.typed) roots_pending[$] = t.want;
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            ra = pick_coef();
            rb = pick_coef();
            rc = pick_coef();
            k = $urandom_range(0, 7);
            // steer some requests into the double-root and linear cases
            if (k == 0 && ra != 0 && rb[0] == 1'b0) rc = 16'((longint'(rb) * rb) / (4 * ra));
            if (k == 1) ra = 0;
            send_coefs(ra, rb, rc);
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: one long hold-off early on, then random stalls, none while n_checked is between 400 and 500
    initial begin
        int gap;
        m_ready <= 1'b0;
        @(posedge aresetn);
        repeat (40) @(posedge aclk);
        for (hold_off = 0; hold_off < 300; hold_off++) @(posedge aclk);
        forever begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
            if (n_checked > 400 && n_checked < 500) gap = 0;
            repeat (gap) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // scoreboard
    initial begin
        res_t w;
        mismatches = 0;
        n_checked  = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (roots_pending.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result class=%0d", m_root_class);
                end else begin
                    w = roots_pending.pop_front();
                    n_checked++;
                    if (m_root_class !== w.cls || m_root_first !== w.root1 ||
                        m_root_second !== w.root2 || m_overflow !== w.ovf) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch #%0d: exp cls=%0d r1=%h r2=%h ovf=%b got cls=%0d r1=%h r2=%h ovf=%b",
                                     n_checked, w.cls, w.root1, w.root2, w.ovf,
                                     m_root_class, m_root_first, m_root_second, m_overflow);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        idle_cycles = 0;
        timed_out = 1'b0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                timed_out = 1'b1;
                $display("watchdog expired with %0d results outstanding", roots_pending.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        wait (stim_done);
        wait (roots_pending.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Checked %0d root results (%0d directed, rest random) with a long", n_checked,
                 N_DIRECTED);
        $display("output stall; all class codes, saturation and degenerate cases exercised.");
        if (mismatches == 0 && !timed_out) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/qrs_pkg.sv
design/qrs_sqrt_cell.sv
design/qrs_div_cell.sv
design/quadratic_root_solver.sv
verif/testbench.sv
